// ===== hw/rtl/ovle_pkg.sv =====
package ovle_pkg;

	// List capacity and derived widths
	localparam int DEPTH  = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [31:0]       word_t;

	localparam cnt_t  CNT_DEPTH  = CNT_W'(DEPTH);
	localparam addr_t ADDR_LAST  = ADDR_W'(DEPTH - 1);

	// Request codes
	localparam logic [2:0] REQ_INSERT     = 3'd0;
	localparam logic [2:0] REQ_SEARCH     = 3'd1;
	localparam logic [2:0] REQ_COUNT      = 3'd2;
	localparam logic [2:0] REQ_REMOVE_ONE = 3'd3;
	localparam logic [2:0] REQ_REMOVE_ALL = 3'd4;
	localparam logic [2:0] REQ_CLEAR      = 3'd5;

	// Write and read request to the entry store
	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	// Result transaction, packed so that found sits in bit 0
	typedef struct packed {
		logic       rejected;
		logic [6:0] occupancy;
		logic [6:0] match_count;
		logic       found;
	} result_t;

	// Map a list position onto the circular store
	function automatic addr_t phys(input addr_t head, input cnt_t pos);
		logic [ADDR_W:0] sum;
		sum = (ADDR_W+1)'(head) + (ADDR_W+1)'(pos);
		if (sum >= (ADDR_W+1)'(DEPTH))
			sum = sum - (ADDR_W+1)'(DEPTH);
		return ADDR_W'(sum);
	endfunction

	// Clamp a count to the 7-bit result fields
	function automatic logic [6:0] sat7(input cnt_t v);
		if (32'(v) > 32'd127)
			return 7'd127;
		else
			return 7'(v);
	endfunction

endpackage

// ===== hw/rtl/ovle_mem.sv =====
module ovle_mem
	import ovle_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output word_t    rdata
);

	word_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.re)
			rdata <= mem[req.raddr];
	end

endmodule

// ===== hw/rtl/ovle_ctrl.sv =====
module ovle_ctrl
	import ovle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] in_req,
	input  word_t      in_value,
	input  logic       out_free,
	output logic       res_valid,
	output result_t    res,
	output mem_req_t   mem,
	input  word_t      rdata
);

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_SCAN    = 4'b0010,
		ST_COMPACT = 4'b0100,
		ST_DONE    = 4'b1000
	} state_t;

	state_t     state_q, state_n;
	addr_t      head_q, head_n;
	cnt_t       count_q, count_n;
	logic [2:0] req_q, req_n;
	word_t      value_q, value_n;
	cnt_t       rd_q, rd_n;
	logic       pend_q, pend_n;
	cnt_t       pidx_q, pidx_n;
	cnt_t       hit_q, hit_n;
	cnt_t       wr_q, wr_n;
	cnt_t       matches_q, matches_n;
	logic       found_q, found_n;
	logic       rej_q, rej_n;
	logic       all_q, all_n;

	cnt_t       half;
	cnt_t       lidx;
	logic       eq;
	logic       skip;

	assign in_ready = (state_q == ST_IDLE);

	// Scan order: plain for search/count, ends-inward for remove one
	always_comb begin
		half = rd_q >> 1;
		if (req_q == REQ_REMOVE_ONE)
			lidx = rd_q[0] ? (count_q - cnt_t'(1) - half) : half;
		else
			lidx = rd_q;
	end

	// Shared compare unit on the returning read data
	assign eq   = pend_q && (rdata == value_q);
	assign skip = all_q ? (rdata == value_q) : (pidx_q == hit_q);

	// Sequencer
	always_comb begin
		state_n   = state_q;
		head_n    = head_q;
		count_n   = count_q;
		req_n     = req_q;
		value_n   = value_q;
		rd_n      = rd_q;
		pend_n    = 1'b0;
		pidx_n    = pidx_q;
		hit_n     = hit_q;
		wr_n      = wr_q;
		matches_n = matches_q;
		found_n   = found_q;
		rej_n     = rej_q;
		all_n     = all_q;
		mem       = '0;
		res_valid = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_n     = in_req;
					value_n   = in_value;
					rd_n      = '0;
					wr_n      = '0;
					matches_n = '0;
					found_n   = 1'b0;
					rej_n     = 1'b0;
					all_n     = 1'b0;
					state_n   = ST_DONE;
					case (in_req)
						REQ_INSERT: begin
							if (count_q == CNT_DEPTH) begin
								rej_n = 1'b1;
							end else begin
								head_n    = (head_q == '0) ? ADDR_LAST : head_q - addr_t'(1);
								mem.we    = 1'b1;
								mem.waddr = head_n;
								mem.wdata = in_value;
								count_n   = count_q + cnt_t'(1);
							end
						end
						REQ_SEARCH, REQ_COUNT, REQ_REMOVE_ONE: begin
							if (count_q != '0)
								state_n = ST_SCAN;
						end
						REQ_REMOVE_ALL: begin
							all_n = 1'b1;
							if (count_q != '0)
								state_n = ST_COMPACT;
						end
						REQ_CLEAR: begin
							count_n = '0;
						end
						default: begin
						end
					endcase
				end
			end

			ST_SCAN: begin
				// Issue the next read
				if (rd_q != count_q) begin
					mem.re    = 1'b1;
					mem.raddr = phys(head_q, lidx);
					pend_n    = 1'b1;
					pidx_n    = lidx;
					rd_n      = rd_q + cnt_t'(1);
				end else begin
					state_n = ST_DONE;
				end
				// Act on the compare of the previous read
				if (eq) begin
					case (req_q)
						REQ_SEARCH: begin
							found_n = 1'b1;
							pend_n  = 1'b0;
							state_n = ST_DONE;
						end
						REQ_REMOVE_ONE: begin
							found_n = 1'b1;
							hit_n   = pidx_q;
							rd_n    = pidx_q;
							wr_n    = pidx_q;
							pend_n  = 1'b0;
							state_n = ST_COMPACT;
						end
						default: begin
							matches_n = matches_q + cnt_t'(1);
						end
					endcase
				end
			end

			ST_COMPACT: begin
				// Read ahead of the write pointer
				if (rd_q != count_q) begin
					mem.re    = 1'b1;
					mem.raddr = phys(head_q, rd_q);
					pend_n    = 1'b1;
					pidx_n    = rd_q;
					rd_n      = rd_q + cnt_t'(1);
				end
				// Drop matching entries, close up the rest
				if (pend_q) begin
					if (skip) begin
						if (all_q)
							matches_n = matches_q + cnt_t'(1);
					end else begin
						mem.we    = 1'b1;
						mem.waddr = phys(head_q, wr_q);
						mem.wdata = rdata;
						wr_n      = wr_q + cnt_t'(1);
					end
				end
				if (rd_q == count_q) begin
					count_n = wr_n;
					state_n = ST_DONE;
				end
			end

			ST_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_n   = ST_IDLE;
				end
			end

			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Result fields
	always_comb begin
		res.found       = found_q;
		res.match_count = sat7(matches_q);
		res.occupancy   = sat7(count_q);
		res.rejected    = rej_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			head_q  <= head_n;
			count_q <= count_n;
			pend_q  <= pend_n;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		req_q     <= req_n;
		value_q   <= value_n;
		rd_q      <= rd_n;
		pidx_q    <= pidx_n;
		hit_q     <= hit_n;
		wr_q      <= wr_n;
		matches_q <= matches_n;
		found_q   <= found_n;
		rej_q     <= rej_n;
		all_q     <= all_n;
	end

endmodule

// ===== hw/rtl/ordered_value_list_engine.sv =====
// Insert, clear and unused codes go straight to the result state; search and count scan the list,
// remove all compacts it in place, and remove one scans from both ends inward and compacts from a
// hit, each bound by the single read port of the entry store and one compare per cycle.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: arst_n clears the list to empty and the control asynchronously; store contents
// are left as they are and never read before written.
module ordered_value_list_engine
	import ovle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [2:0]  s_tuser,   // [2:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] found, [7:1] match_count, [14:8] occupancy, [15] rejected
);

	mem_req_t mem;
	word_t    rdata;
	logic     res_valid;
	result_t  res;
	logic     out_free;
	logic     tvalid_q;
	result_t  tdata_q;

	ovle_mem u_mem (
		.clk   (clk),
		.req   (mem),
		.rdata (rdata)
	);

	ovle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (s_tuser),
		.in_value  (s_tdata),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res),
		.mem       (mem),
		.rdata     (rdata)
	);

	assign out_free = !tvalid_q || m_tready;

	// Output register: hold until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tvalid_q <= 1'b0;
		else if (res_valid)
			tvalid_q <= 1'b1;
		else if (m_tready)
			tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			tdata_q <= res;
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;

endmodule

// ===== hw/rtl/ovle_chk.sv =====
module ovle_chk
	import ovle_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Busy right after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// Occupancy never exceeds capacity
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[14:8]) <= DEPTH)
		else $error("occupancy beyond capacity");

	// A rejected insert reports no hit and no count
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |-> m_tdata[7:0] == 8'd0)
		else $error("rejected result with hit or count");

	// Hit and count never reported together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[7:1] == 7'd0)
		else $error("found and match_count both set");

endmodule

bind ordered_value_list_engine ovle_chk u_ovle_chk (.*);
